/* rtl/smrg_pkg.sv */
// Shared widths, constants and types of the shuffled minimal-standard generator.
package smrg_pkg;

   localparam int VALUE_W          = 31;
   localparam int OPERAND_W        = 32;
   localparam int MULT_W           = 15;
   localparam int PROD_W           = 46;
   localparam int SLOT_SHIFT       = 26;
   localparam int TABLE_DEPTH_DEF  = 32;
   localparam int WARMUP_STEPS_DEF = 40;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int REQ_DATA_W       = 8;
   localparam int RSP_DATA_W       = 32;

   localparam logic [MULT_W-1:0]  LCG_MULT = 15'd16807;
   localparam logic [VALUE_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;

   localparam logic REG_SEED = 1'b0;

   typedef logic [VALUE_W-1:0]   value_type;
   typedef logic [OPERAND_W-1:0] operand_type;

endpackage

/* rtl/shuffled_minstd_random_generator.sv */
// Top level of the shuffled minimal-standard random generator.
//
//   Channel  Direction  Handshake               Payload
//   req      in         req_tvalid/req_tready   req_tdata[0] = restart
//   rsp      out        rsp_tvalid/rsp_tready   rsp_tdata[30:0] = value
//   csr      in         APB, pready always high seed register at byte address 0
//
// A draw passes through the accepting idle state and the reduce state, and its result is
// registered in the reduce state unless a waiting result holds it there.
// A restart, or the first request after reset, first runs WARMUP_STEPS warm-up steps,
// each a multiply state and a reduce state of the one shared unit, then the draw.
// The block accepts one request at a time; a waiting result holds the block in its last step.
// Reset is synchronous; the shuffle table needs no clearing since a restart fills it.
module shuffled_minstd_random_generator #(
   parameter int TABLE_DEPTH  = smrg_pkg::TABLE_DEPTH_DEF,
   parameter int WARMUP_STEPS = smrg_pkg::WARMUP_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [smrg_pkg::REQ_DATA_W-1:0] req_tdata,   // [0] restart, zero filled above
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smrg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [30:0] value, zero filled above
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [smrg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [smrg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [smrg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   import smrg_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(WARMUP_STEPS);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_WARM_MUL = 5'b00010,
      ST_WARM_RED = 5'b00100,
      ST_DRAW_MUL = 5'b01000,
      ST_DRAW_RED = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CSR_DATA_W-1:0] seed_ff, seed_in;
   logic               seeded_ff, seeded_in;
   value_type          lcg_ff, lcg_in;
   value_type          last_ff, last_in;
   operand_type        work_ff, work_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   value_type          rsp_value_ff, rsp_value_in;

   logic               csr_wr;
   logic               req_acc;
   operand_type        seed_mag;
   operand_type        start_val;
   operand_type        operand;
   value_type          step_val;
   logic [4:0]         slot_q;
   logic [4:0]         slot_fix;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   value_type          wr_data;
   value_type          rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SEED) ? seed_ff : '0;
   assign seed_in    = (csr_wr && csr_paddr[2] == REG_SEED) ? csr_pwdata : seed_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;

   assign seed_mag  = seed_ff[CSR_DATA_W-1] ? (~seed_ff + 1'b1) : seed_ff;
   assign start_val = (seed_mag == '0) ? operand_type'(1) : seed_mag;

   assign operand = (state_ff == ST_WARM_MUL) ? work_ff : {1'b0, lcg_ff};

   smrg_lcg_unit u_lcg (
      .clock   (clock),
      .operand (operand),
      .result  (step_val)
   );

   // Slot is last / (2^26 + 1): the top bits, less one where the low bits fall short.
   assign slot_q   = last_ff[VALUE_W-1:SLOT_SHIFT];
   assign slot_fix = (last_ff[SLOT_SHIFT-1:0] < {{(SLOT_SHIFT - 5){1'b0}}, slot_q})
                   ? slot_q - 5'd1 : slot_q;
   assign rd_addr  = slot_fix[AW-1:0];

   smrg_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      lcg_in       = lcg_ff;
      last_in      = last_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = rd_addr;
      wr_data      = step_val;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tdata[0] || !seeded_ff) begin
                  work_in  = start_val;
                  cnt_in   = CW'(WARMUP_STEPS - 1);
                  state_in = ST_WARM_MUL;
               end else begin
                  state_in = ST_DRAW_RED;
               end
            end
         end
         ST_WARM_MUL: begin
            state_in = ST_WARM_RED;
         end
         ST_WARM_RED: begin
            work_in = {1'b0, step_val};
            wr_addr = cnt_ff[AW-1:0];
            wr_en   = (32'(cnt_ff) < TABLE_DEPTH);
            if (cnt_ff == '0) begin
               lcg_in    = step_val;
               last_in   = step_val;
               seeded_in = 1'b1;
               state_in  = ST_DRAW_MUL;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_WARM_MUL;
            end
         end
         ST_DRAW_MUL: begin
            state_in = ST_DRAW_RED;
         end
         ST_DRAW_RED: begin
            if (!rsp_valid_ff || rsp_tready) begin
               wr_en        = 1'b1;
               lcg_in       = step_val;
               last_in      = rd_data;
               rsp_value_in = rd_data;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= CSR_DATA_W'(1);
         seeded_ff    <= 1'b0;
         lcg_ff       <= value_type'(1);
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         seeded_ff    <= seeded_in;
         lcg_ff       <= lcg_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W){1'b0}}, rsp_value_ff};

endmodule

/* rtl/smrg_ram.sv */
// Generic single-port-write, registered-read RAM used for the shuffle table.
module smrg_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/smrg_lcg_unit.sv */
// Shared generator step: registered multiply by 16807, then reduction modulo 2^31-1.
module smrg_lcg_unit (
   input  logic                 clock,
   input  smrg_pkg::operand_type operand,
   output smrg_pkg::value_type   result
);

   import smrg_pkg::*;

   logic [PROD_W:0]     prod_full;
   logic [PROD_W-1:0]   prod_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [VALUE_W:0]    sum;
   logic [VALUE_W:0]    diff;

   assign prod_full = {{(PROD_W + 1 - OPERAND_W){1'b0}}, operand}
                    * {{(PROD_W + 1 - MULT_W){1'b0}}, LCG_MULT};
   assign prod_in   = prod_full[PROD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign sum  = {1'b0, prod_ff[VALUE_W-1:0]}
               + {{(VALUE_W + 1 - (PROD_W - VALUE_W)){1'b0}}, prod_ff[PROD_W-1:VALUE_W]};
   assign diff = sum - {1'b0, LCG_MOD};

   assign result = (sum >= {1'b0, LCG_MOD}) ? diff[VALUE_W-1:0] : sum[VALUE_W-1:0];

endmodule

/* bench/shuffled_minstd_random_generator_test.sv */
// Self-checking bench of the shuffled minimal-standard generator, predicting unpinned draws.
`timescale 1ns / 100ps

module shuffled_minstd_random_generator_test;
   import smrg_pkg::*;

   localparam int                    SLOT_W          = $clog2(TABLE_DEPTH_DEF);
   localparam logic [VALUE_W-1:0]    SLOT_DIVISOR    = 31'd67108865;
   localparam logic [CSR_ADDR_W-1:0] SEED_ADDR       = {REG_SEED, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR     = 3'd4;
   localparam int                    RANDOM_PER_PHASE = 250;
   localparam int                    DRAIN_CYCLES    = 2 * WARMUP_STEPS_DEF + 8;

   typedef struct packed {
      logic                  csr_write;
      logic [CSR_ADDR_W-1:0] csr_addr;
      logic [CSR_DATA_W-1:0] csr_data;
      logic                  restart;
      logic                  pinned;
      value_type             pinned_value;
   } drill_row_type;

   localparam int DRILL_COUNT = 20;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  req_pinned       = 1'b0;
   value_type             req_pinned_value = '0;

   int unsigned sender_idle_pct   = 36;
   int unsigned receiver_idle_pct = 69;
   int unsigned mismatch_count    = 0;

   value_type   pending_values[$];
   operand_type seed_shadow   = 32'd1;
   value_type   lcg_shadow    = 31'd1;
   value_type   last_shadow   = '0;
   logic        seeded_shadow = 1'b0;
   value_type   shuffle_shadow[TABLE_DEPTH_DEF];

   drill_row_type drill_rows[DRILL_COUNT] = '{
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b1, 1'b0, 31'd0},
      '{1'b1, SEED_ADDR,   32'h0000_0000, 1'b1, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b1, SEED_ADDR,   32'hFFFF_FFFF, 1'b1, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b1, SEED_ADDR,   32'h7FFF_FFFF, 1'b1, 1'b1, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b1, 31'd0},
      '{1'b1, SEED_ADDR,   32'h8000_0001, 1'b1, 1'b1, 31'd0},
      '{1'b1, SEED_ADDR,   32'h8000_0000, 1'b1, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b1, SEED_ADDR,   32'h7FFF_FFFE, 1'b1, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b1, UNUSED_ADDR, 32'h0000_1234, 1'b1, 1'b0, 31'd0},
      '{1'b1, SEED_ADDR,   32'd12345,     1'b0, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b1, 1'b0, 31'd0},
      '{1'b0, SEED_ADDR,   32'h0000_0000, 1'b0, 1'b0, 31'd0}
   };

   shuffled_minstd_random_generator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [0] restart, zero filled above
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [30:0] value, zero filled above
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic value_type minstd_step(input operand_type x);
      logic [63:0] product;
      product = 64'(x) * 64'(LCG_MULT);
      return value_type'(product % 64'(LCG_MOD));
   endfunction

   function automatic value_type draw_value(input logic restart);
      operand_type       magnitude;
      logic [SLOT_W-1:0] slot;
      value_type         drawn;
      if (restart || !seeded_shadow) begin
         magnitude = seed_shadow;
         if (magnitude[OPERAND_W-1]) magnitude = -magnitude;
         if (magnitude == '0) magnitude = 32'd1;
         for (int i = WARMUP_STEPS_DEF - 1; i >= 0; i--) begin
            magnitude = {1'b0, minstd_step(magnitude)};
            if (i < TABLE_DEPTH_DEF) shuffle_shadow[i] = magnitude[VALUE_W-1:0];
         end
         lcg_shadow    = magnitude[VALUE_W-1:0];
         last_shadow   = shuffle_shadow[0];
         seeded_shadow = 1'b1;
      end
      lcg_shadow           = minstd_step({1'b0, lcg_shadow});
      slot                 = SLOT_W'(last_shadow / SLOT_DIVISOR);
      drawn                = shuffle_shadow[slot];
      shuffle_shadow[slot] = lcg_shadow;
      last_shadow          = drawn;
      return drawn;
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      value_type wanted;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_values.size() == 0) begin
               $error("value: expected none, actual %0d", rsp_tdata[VALUE_W-1:0]);
               mismatch_count++;
            end else begin
               wanted = pending_values.pop_front();
               if (rsp_tdata[VALUE_W-1:0] !== wanted) begin
                  $error("value: expected %0d, actual %0d", wanted, rsp_tdata[VALUE_W-1:0]);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            wanted = draw_value(req_tdata[0]);
            if (req_pinned) wanted = req_pinned_value;
            pending_values.push_back(wanted);
         end
      end
   end

   task automatic send_request(input logic restart, input logic pinned, input value_type pin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid       <= 1'b1;
      req_tdata        <= {{(REQ_DATA_W - 1){1'b0}}, restart};
      req_pinned       <= pinned;
      req_pinned_value <= pin;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_values.size() != 0);
   endtask

   // The seed is read back after every write, so an ignored write shows up as well.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == SEED_ADDR) seed_shadow = data;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= SEED_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== seed_shadow) begin
         $error("seed: expected %0h, actual %0h", seed_shadow, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (drill_rows[i]) begin
         if (drill_rows[i].csr_write) begin
            drain_requests();
            write_csr(drill_rows[i].csr_addr, drill_rows[i].csr_data);
         end
         send_request(drill_rows[i].restart, drill_rows[i].pinned, drill_rows[i].pinned_value);
      end

      for (int phase = 0; phase < 3; phase++) begin
         drain_requests();
         case (phase)
            0: begin
               sender_idle_pct   = 36;
               receiver_idle_pct = 69;
            end
            1: begin
               sender_idle_pct   = 69;
               receiver_idle_pct = 36;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         write_csr(SEED_ADDR, $urandom());
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request($urandom_range(99) < 6, 1'b0, '0);
         end
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("shuffled_minstd_random_generator test passed");
      end else begin
         $display("shuffled_minstd_random_generator test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("shuffled_minstd_random_generator test failed");
      $finish;
   end

endmodule

/* files.f */
rtl/smrg_pkg.sv
rtl/smrg_ram.sv
rtl/smrg_lcg_unit.sv
rtl/shuffled_minstd_random_generator.sv
bench/shuffled_minstd_random_generator_test.sv
